// ===== hdl/tctod_pkg.sv =====
// shared types and constants for the tick-calibrated time-of-day unit
// used by tctod_mul, tctod_div and tick_calibrated_time_of_day
package tctod_pkg;

   // datapath width of seconds, tick deltas, products and quotients
   localparam int DATA_BITS = 64;
   localparam int CNT_BITS  = $clog2(DATA_BITS + 1);

   // nanoseconds per second and its width
   localparam int                NS_BITS    = 30;
   localparam logic [NS_BITS-1:0] NS_PER_SEC = NS_BITS'(1000000000);
   localparam int                NS_CNT_BITS = $clog2(NS_BITS + 1);

   // action codes
   localparam logic [1:0] ACT_INIT = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   // bit-serial multiplier request and status
   typedef struct packed {
      logic                 start;
      logic [DATA_BITS-1:0] multiplicand;
      logic [NS_BITS-1:0]   multiplier;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [DATA_BITS-1:0] product;
   } mul_rsp_type;

   // bit-serial divider request and status
   typedef struct packed {
      logic                 start;
      logic [DATA_BITS-1:0] dividend;
      logic [DATA_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DATA_BITS-1:0] quotient;
      logic [DATA_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hdl/tctod_mul.sv =====
// shift-and-add multiplier, one multiplier bit per cycle, product wraps at 64 bits
// depends on tctod_pkg
module tctod_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  tctod_pkg::mul_req_type req,
   output tctod_pkg::mul_rsp_type rsp
);

   logic [tctod_pkg::DATA_BITS-1:0]   acc_ff, acc_in;
   logic [tctod_pkg::DATA_BITS-1:0]   mcand_ff, mcand_in;
   logic [tctod_pkg::NS_BITS-1:0]     mplier_ff, mplier_in;
   logic [tctod_pkg::NS_CNT_BITS-1:0] count_ff, count_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   // one partial product per cycle, multiplicand shifts up, multiplier down
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         acc_in    = '0;
         mcand_in  = req.multiplicand;
         mplier_in = req.multiplier;
         count_in  = tctod_pkg::NS_CNT_BITS'(tctod_pkg::NS_BITS);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[tctod_pkg::DATA_BITS-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[tctod_pkg::NS_BITS-1:1]};
         count_in  = count_ff - 1'b1;
         if (count_ff == tctod_pkg::NS_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// ===== hdl/tctod_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tctod_pkg; divisor must be nonzero
module tctod_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tctod_pkg::div_req_type req,
   output tctod_pkg::div_rsp_type rsp
);

   logic [tctod_pkg::DATA_BITS-1:0] rem_ff, rem_in;
   logic [tctod_pkg::DATA_BITS-1:0] quo_ff, quo_in;
   logic [tctod_pkg::DATA_BITS-1:0] dvs_ff, dvs_in;
   logic [tctod_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [tctod_pkg::DATA_BITS:0]   trial;
   logic [tctod_pkg::DATA_BITS:0]   diff;
   logic                            fits;

   // shifted partial remainder against the divisor
   assign trial = {rem_ff, quo_ff[tctod_pkg::DATA_BITS-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   // dividend bits leave the top of the quotient register as quotient bits enter
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = '0;
         quo_in   = req.dividend;
         dvs_in   = req.divisor;
         count_in = tctod_pkg::CNT_BITS'(tctod_pkg::DATA_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[tctod_pkg::DATA_BITS-1:0] : trial[tctod_pkg::DATA_BITS-1:0];
         quo_in   = {quo_ff[tctod_pkg::DATA_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == tctod_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== hdl/tick_calibrated_time_of_day.sv =====
// top level of the tick-calibrated time-of-day unit
// depends on tctod_pkg, tctod_mul and tctod_div
//
// Usage:
//   req channel: one beat per action. tuser selects the action (init, tick,
//   read) and flags the RTC read as valid; tdata carries the counter value
//   and the RTC seconds. rsp channel: one beat per request with seconds,
//   nanoseconds and the tick frequency after the action.
//   csr_wr_en/csr_wr_data load min_seconds (0 acts as 1); write only idle.
// Throughput and sequencing:
//   one request at a time; req_tready is high only while no request is in
//   work. init, tick without recalibration and uncalibrated reads without
//   calibration go from the decide state straight to the output state. A
//   recalibration runs the bit-serial divider. A calibrated read runs the
//   serial multiplier (one bit of 1e9 per cycle) and two 64-step divides in
//   turn. These serial units set the rate.
// Reset:
//   clears the time base, frequency (uncalibrated) and sets min_seconds to 1.
// Stall:
//   the result sits in an output register; if rsp_tready is low the unit
//   holds a finished result until the register frees, and takes no new beat.
module tick_calibrated_time_of_day #(
   parameter int COUNTER_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // counter_value[63:0], rtc_seconds[127:64]
   input  logic [2:0]   req_tuser,   // action[1:0], rtc_valid[2]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // seconds[63:0], nanoseconds[93:64],
                                     // tick_frequency[157:94], zero[159:158]
   // configuration
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data  // min_seconds
);

   localparam int DB = tctod_pkg::DATA_BITS;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECIDE = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_RDIV   = 7'b0001000,
      ST_SDIV   = 7'b0010000,
      ST_CAL    = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // persistent state
   logic [DB-1:0]           base_seconds_ff, base_seconds_in;
   logic [COUNTER_BITS-1:0] base_tick_ff, base_tick_in;
   logic [DB-1:0]           tps_ff, tps_in;
   logic [7:0]              min_seconds_ff;

   // latched request
   logic [1:0]              action_ff;
   logic [COUNTER_BITS-1:0] now_ff;
   logic [DB-1:0]           rtc_ff;
   logic                    valid_ff;

   // pending result
   logic [DB-1:0]                   res_secs_ff, res_secs_in;
   logic [tctod_pkg::NS_BITS-1:0]   res_ns_ff, res_ns_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [159:0] rsp_data_ff, rsp_data_in;

   // serial units
   tctod_pkg::mul_req_type mul_req;
   tctod_pkg::mul_rsp_type mul_rsp;
   tctod_pkg::div_req_type div_req;
   tctod_pkg::div_rsp_type div_rsp;

   logic                    req_beat;
   logic [COUNTER_BITS-1:0] delta;
   logic [DB-1:0]           delta_ext;
   logic [DB-1:0]           sec_diff;
   logic [31:0]             elapsed;
   logic [7:0]              need;
   logic [DB-1:0]           rtc_or_zero;
   logic [DB-1:0]           cal_freq;

   tctod_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   tctod_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;

   // deltas against the time base
   assign delta       = now_ff - base_tick_ff;
   assign delta_ext   = DB'(delta);
   assign sec_diff    = rtc_ff - base_seconds_ff;
   assign elapsed     = sec_diff[31:0];
   assign need        = (min_seconds_ff == 8'd0) ? 8'd1 : min_seconds_ff;
   assign rtc_or_zero = valid_ff ? rtc_ff : '0;
   assign cal_freq    = (div_rsp.quotient == '0) ? DB'(1) : div_rsp.quotient;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      base_seconds_in = base_seconds_ff;
      base_tick_in    = base_tick_ff;
      tps_in          = tps_ff;
      res_secs_in     = res_secs_ff;
      res_ns_in       = res_ns_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      rsp_data_in     = rsp_data_ff;

      mul_req.start        = 1'b0;
      mul_req.multiplicand = delta_ext;
      mul_req.multiplier   = tctod_pkg::NS_PER_SEC;

      div_req.start    = 1'b0;
      div_req.dividend = delta_ext;
      div_req.divisor  = DB'(elapsed);

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_ns_in   = '0;
            res_secs_in = base_seconds_ff;
            state_in    = ST_OUT;
            case (action_ff)
               tctod_pkg::ACT_INIT: begin
                  base_tick_in    = now_ff;
                  base_seconds_in = rtc_or_zero;
                  res_secs_in     = rtc_or_zero;
               end
               tctod_pkg::ACT_TICK: begin
                  if (valid_ff && (elapsed >= 32'(need))) begin
                     div_req.start = 1'b1;
                     state_in      = ST_CAL;
                  end
               end
               tctod_pkg::ACT_READ: begin
                  if (tps_ff != '0) begin
                     mul_req.start = 1'b1;
                     state_in      = ST_MUL;
                  end else begin
                     res_secs_in = rtc_or_zero;
                     // calibrate from the rtc when it has moved past the base
                     if (valid_ff && (rtc_ff > base_seconds_ff) && (elapsed != '0)) begin
                        div_req.start = 1'b1;
                        state_in      = ST_CAL;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_CAL: begin
            if (div_rsp.done) begin
               tps_in          = cal_freq;
               base_seconds_in = rtc_ff;
               base_tick_in    = now_ff;
               res_secs_in     = rtc_ff;
               state_in        = ST_OUT;
            end
         end
         ST_MUL: begin
            div_req.dividend = mul_rsp.product;
            div_req.divisor  = tps_ff;
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               state_in      = ST_RDIV;
            end
         end
         ST_RDIV: begin
            // split elapsed nanoseconds into whole seconds and fraction
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = DB'(tctod_pkg::NS_PER_SEC);
            if (div_rsp.done) begin
               div_req.start = 1'b1;
               state_in      = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (div_rsp.done) begin
               res_secs_in = base_seconds_ff + div_rsp.quotient;
               res_ns_in   = div_rsp.remainder[tctod_pkg::NS_BITS-1:0];
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, tps_ff, res_ns_ff, res_secs_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         base_seconds_ff <= '0;
         base_tick_ff    <= '0;
         tps_ff          <= '0;
         min_seconds_ff  <= 8'd1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         base_seconds_ff <= base_seconds_in;
         base_tick_ff    <= base_tick_in;
         tps_ff          <= tps_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_wr_en) begin
            min_seconds_ff <= csr_wr_data;
         end
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         action_ff <= req_tuser[1:0];
         valid_ff  <= req_tuser[2];
         now_ff    <= req_tdata[COUNTER_BITS-1:0];
         rtc_ff    <= req_tdata[127:64];
      end
      res_secs_ff <= res_secs_in;
      res_ns_ff   <= res_ns_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // divider results arrive only while a divide is being waited on
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_CAL || state_ff == ST_RDIV || state_ff == ST_SDIV))
      else $error("divider finished outside a divide state");

   // multiplier results arrive only in the multiply state
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside the multiply state");

   // a calibration always leaves a nonzero frequency
   a_cal_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAL && div_rsp.done) |=> (tps_ff != '0))
      else $error("calibration stored a zero frequency");

   // fraction of a second stays below one second
   a_ns_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SDIV && div_rsp.done) |-> (div_rsp.remainder < DB'(tctod_pkg::NS_PER_SEC)))
      else $error("nanosecond remainder out of range");

   // a calibrated read only starts with a known frequency
   a_read_freq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (tps_ff != '0))
      else $error("calibrated read without a frequency");

endmodule

// ===== dv/tick_calibrated_time_of_day_test.sv =====
`timescale 1ns / 100ps
// testbench for tick_calibrated_time_of_day: a directed table, then random beats, all
// checked beat by beat against pinned results or an in-bench time-of-day predictor
// depends on tctod_pkg and the tick_calibrated_time_of_day rtl
module tick_calibrated_time_of_day_test;

   localparam int          CNT_W           = 64;
   localparam logic [63:0] CNT_MASK        = {64{1'b1}} >> (64 - CNT_W);
   localparam logic [63:0] NS_SEC64        = 64'd1_000_000_000;
   localparam logic [63:0] ALL_ONES        = {64{1'b1}};
   localparam int          IDLE_LIMIT      = 3000;
   localparam int          SETTLE_CYCLES   = 200;
   localparam int          RANDOM_PHASES   = 6;
   localparam int          BEATS_PER_PHASE = 64;

   typedef struct {
      logic [tctod_pkg::DATA_BITS-1:0] secs;
      logic [tctod_pkg::NS_BITS-1:0]   nsec;
      logic [tctod_pkg::DATA_BITS-1:0] freq;
   } tod_result_type;

   typedef struct {
      logic [1:0]  act;
      logic [63:0] count;
      logic [63:0] rtc;
      logic        rtc_ok;
   } tod_req_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      tod_req_type    req;
      logic           pinned;
      tod_result_type pin;
      logic [7:0]     csr_val;
   } stim_row_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata   = '0;   // counter_value[63:0], rtc_seconds[127:64]
   logic [2:0]   req_tuser   = '0;   // action[1:0], rtc_valid[2]
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [159:0] rsp_tdata;         // seconds[63:0], nanoseconds[93:64],
                                    // tick_frequency[157:94], zero[159:158]
   logic         csr_wr_en   = 1'b0;
   logic [7:0]   csr_wr_data = '0;  // min_seconds

   tick_calibrated_time_of_day #(
      .COUNTER_BITS(CNT_W)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // predictor copy of the time base, frequency and min_seconds
   logic [63:0] tod_base_secs  = '0;
   logic [63:0] tod_base_count = '0;
   logic [63:0] tod_rate       = '0;
   logic [7:0]  tod_min_secs   = 8'd1;

   // generator position for well-formed sequences
   logic [63:0] walk_rtc   = '0;
   logic [63:0] walk_count = '0;
   logic [63:0] walk_rate  = 64'd1;

   tod_result_type pending_results[$];
   stim_row_type   stim_rows[$];

   int send_idle_pct  = 18;
   int rcv_idle_pct   = 53;
   int failures       = 0;
   int beats_sent     = 0;
   int results_seen   = 0;
   int recal_count    = 0;
   int cal_read_count = 0;
   int csr_writes     = 0;
   int stall_cycles   = 0;

   // rebase on a new frequency measurement, zero rate stored as one
   function automatic void tod_recalibrate(logic [63:0] count, logic [63:0] secs,
                                           logic [31:0] elapsed);
      logic [63:0] f;
      f = ((count - tod_base_count) & CNT_MASK) / {32'd0, elapsed};
      if (f == 0) f = 64'd1;
      tod_rate       = f;
      tod_base_secs  = secs;
      tod_base_count = count;
      recal_count++;
   endfunction

   // expected result of one request beat, advances the predictor state
   function automatic tod_result_type tod_predict(tod_req_type rq);
      tod_result_type res;
      logic [63:0] count;
      logic [63:0] delta;
      logic [63:0] nsec_total;
      logic [63:0] rtc_now;
      logic [31:0] elapsed;
      logic [31:0] need;
      count    = rq.count & CNT_MASK;
      rtc_now  = rq.rtc_ok ? rq.rtc : 64'd0;
      res.nsec = '0;
      case (rq.act)
         tctod_pkg::ACT_INIT: begin
            tod_base_count = count;
            tod_base_secs  = rtc_now;
            res.secs       = tod_base_secs;
         end
         tctod_pkg::ACT_READ: begin
            if (tod_rate != 0) begin
               delta      = (count - tod_base_count) & CNT_MASK;
               nsec_total = (delta * NS_SEC64) / tod_rate;
               res.secs   = tod_base_secs + nsec_total / NS_SEC64;
               res.nsec   = tctod_pkg::NS_BITS'(nsec_total % NS_SEC64);
               cal_read_count++;
            end else begin
               // fall back on the rtc, learn the rate once it moved past the base
               res.secs = rtc_now;
               elapsed  = 32'(rtc_now - tod_base_secs);
               if (rtc_now > tod_base_secs && elapsed != 0)
                  tod_recalibrate(count, rtc_now, elapsed);
            end
         end
         default: begin
            if (rq.act == tctod_pkg::ACT_TICK && rq.rtc_ok) begin
               elapsed = 32'(rq.rtc - tod_base_secs);
               need    = (tod_min_secs == 0) ? 32'd1 : {24'd0, tod_min_secs};
               if (elapsed >= need) tod_recalibrate(count, rq.rtc, elapsed);
            end
            res.secs = tod_base_secs;
         end
      endcase
      res.freq = tod_rate;
      return res;
   endfunction

   function automatic void add_beat(logic [1:0] act, logic [63:0] count, logic [63:0] rtc,
                                    logic ok, logic pinned = 1'b0, logic [63:0] s = '0,
                                    logic [tctod_pkg::NS_BITS-1:0] n = '0,
                                    logic [63:0] f = '0);
      stim_row_type row;
      row.kind    = ROW_BEAT;
      row.req     = '{act, count, rtc, ok};
      row.pinned  = pinned;
      row.pin     = '{s, n, f};
      row.csr_val = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [7:0] v);
      stim_row_type row;
      row.kind    = ROW_CSR;
      row.req     = '{tctod_pkg::ACT_NONE, 64'd0, 64'd0, 1'b0};
      row.pinned  = 1'b0;
      row.pin     = '{64'd0, '0, 64'd0};
      row.csr_val = v;
      stim_rows.push_back(row);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_or_rand64();
      case ($urandom_range(0, 3))
         0:       return 64'd0;
         1:       return ALL_ONES;
         default: return rand64();
      endcase
   endfunction

   // mostly well-formed init/tick/read sequences along a steady rate, some noise
   function automatic tod_req_type next_random_beat();
      tod_req_type rq;
      int          roll;
      logic [63:0] dt;
      roll      = $urandom_range(0, 99);
      rq.rtc_ok = ($urandom_range(0, 15) != 0);
      if (roll < 25) begin
         rq.act    = 2'($urandom_range(0, 3));
         rq.count  = edge_or_rand64();
         rq.rtc    = edge_or_rand64();
         rq.rtc_ok = 1'($urandom_range(0, 1));
         return rq;
      end
      if (roll < 32) begin
         walk_rtc   = ($urandom_range(0, 1) != 0) ? rand64() : 64'($urandom_range(0, 1000));
         walk_count = rand64();
         rq.act     = tctod_pkg::ACT_INIT;
      end else if (roll < 62) begin
         dt         = 64'($urandom_range(0, 2 * tod_min_secs + 2));
         walk_rtc   = walk_rtc + dt;
         walk_count = walk_count + dt * walk_rate + 64'($urandom_range(0, 1000));
         rq.act     = tctod_pkg::ACT_TICK;
      end else if (roll < 96) begin
         walk_count = walk_count + (walk_rate / 1000) * 64'($urandom_range(0, 3000))
                      + 64'($urandom_range(0, 7));
         rq.act     = tctod_pkg::ACT_READ;
      end else begin
         rq.act = tctod_pkg::ACT_NONE;
      end
      rq.count = walk_count;
      rq.rtc   = walk_rtc;
      return rq;
   endfunction

   // drive one request beat, predict it once accepted
   task automatic send_beat(tod_req_type rq, logic pinned, tod_result_type pin);
      tod_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rq.rtc, rq.count};
      req_tuser  <= {rq.rtc_ok, rq.act};
      do @(posedge clock); while (!req_tready);
      res = tod_predict(rq);
      if (pinned) pending_results.push_back(pin);
      else pending_results.push_back(res);
      beats_sent++;
      @(negedge clock);
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_min_secs(logic [7:0] v);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      tod_min_secs  = v;
      csr_writes++;
   endtask

   // result side backpressure
   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      tod_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: seconds %0d", rsp_tdata[63:0]);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[63:0] !== want.secs) begin
               $error("seconds: expected %0d, actual %0d", want.secs, rsp_tdata[63:0]);
               failures++;
            end
            if (rsp_tdata[93:64] !== want.nsec) begin
               $error("nanoseconds: expected %0d, actual %0d", want.nsec, rsp_tdata[93:64]);
               failures++;
            end
            if (rsp_tdata[157:94] !== want.freq) begin
               $error("tick_frequency: expected %0d, actual %0d", want.freq,
                      rsp_tdata[157:94]);
               failures++;
            end
            if (rsp_tdata[159:158] !== 2'b00) begin
               $error("zero pad: expected 0, actual %0d", rsp_tdata[159:158]);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles == IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      tod_result_type no_pin;
      logic [7:0]     phase_min [RANDOM_PHASES];
      int             directed_beats;
      no_pin = '{64'd0, '0, 64'd0};

      // uncalibrated: invalid rtc, tick without rtc, unused action, zero elapsed
      add_beat(tctod_pkg::ACT_READ, 64'd0, ALL_ONES, 1'b0, 1'b1, 64'd0, 0, 64'd0);
      add_beat(tctod_pkg::ACT_TICK, 64'd123, 64'd55, 1'b0, 1'b1, 64'd0, 0, 64'd0);
      add_beat(tctod_pkg::ACT_NONE, 64'd77, 64'd77, 1'b1, 1'b1, 64'd0, 0, 64'd0);
      add_beat(tctod_pkg::ACT_TICK, 64'd5, 64'd0, 1'b1, 1'b1, 64'd0, 0, 64'd0);
      add_beat(tctod_pkg::ACT_INIT, 64'd1000, 64'd100, 1'b1, 1'b1, 64'd100, 0, 64'd0);
      // elapsed a multiple of 2^32, rtc below and equal to the base
      add_beat(tctod_pkg::ACT_READ, 64'd2000, 64'h1_0000_0064, 1'b1, 1'b1,
               64'h1_0000_0064, 0, 64'd0);
      add_beat(tctod_pkg::ACT_READ, 64'd3000, 64'd50, 1'b1, 1'b1, 64'd50, 0, 64'd0);
      add_beat(tctod_pkg::ACT_READ, 64'd0, 64'd100, 1'b1, 1'b1, 64'd100, 0, 64'd0);
      add_beat(tctod_pkg::ACT_INIT, ALL_ONES, 64'd999, 1'b0, 1'b1, 64'd0, 0, 64'd0);
      add_csr(8'd255);
      add_beat(tctod_pkg::ACT_TICK, 64'd10, 64'd200, 1'b1, 1'b1, 64'd0, 0, 64'd0);
      // uncalibrated read learns the rate, counter wraps past the base
      add_beat(tctod_pkg::ACT_READ, 64'd5, 64'd3, 1'b1, 1'b1, 64'd3, 0, 64'd2);
      // min_seconds zero acts as one
      add_csr(8'd0);
      add_beat(tctod_pkg::ACT_TICK, 64'd1005, 64'd4, 1'b1, 1'b1, 64'd4, 0, 64'd1000);
      add_csr(8'd255);
      add_beat(tctod_pkg::ACT_TICK, 64'd9999, 64'd258, 1'b1, 1'b1, 64'd4, 0, 64'd1000);
      add_beat(tctod_pkg::ACT_TICK, 64'd255_001_005, 64'd259, 1'b1, 1'b1, 64'd259, 0,
               64'd1_000_000);
      add_beat(tctod_pkg::ACT_READ, 64'd256_501_005, 64'd0, 1'b0, 1'b1, 64'd260,
               500_000_000, 64'd1_000_000);
      add_beat(tctod_pkg::ACT_READ, 64'd255_001_005, 64'd0, 1'b1, 1'b1, 64'd259, 0,
               64'd1_000_000);
      // largest delta, the product wraps
      add_beat(tctod_pkg::ACT_READ, 64'd255_001_004, 64'd0, 1'b1);
      add_csr(8'd1);
      add_beat(tctod_pkg::ACT_TICK, 64'd0, ALL_ONES, 1'b1);
      add_beat(tctod_pkg::ACT_READ, ALL_ONES, ALL_ONES, 1'b1);
      add_beat(tctod_pkg::ACT_NONE, 64'd1, 64'd2, 1'b1);
      add_beat(tctod_pkg::ACT_INIT, ALL_ONES, ALL_ONES, 1'b1);
      // rtc wraps to zero, one tick in one second gives rate one
      add_beat(tctod_pkg::ACT_TICK, 64'd0, 64'd0, 1'b1, 1'b1, 64'd0, 0, 64'd1);
      add_beat(tctod_pkg::ACT_READ, 64'd3_000_000_000, 64'd0, 1'b1);
      add_beat(tctod_pkg::ACT_TICK, 64'd5, 64'd9, 1'b0);

      // reset, then the directed table
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) write_min_secs(stim_rows[i].csr_val);
         else send_beat(stim_rows[i].req, stim_rows[i].pinned, stim_rows[i].pin);
      end
      directed_beats = beats_sent;

      // random phases, each with its own min_seconds and rate, one idle mix per pair of phases
      phase_min = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254)), 8'd2,
                    8'($urandom_range(3, 254))};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_min_secs(phase_min[p]);
         case (p / 2)
            0:       begin send_idle_pct = 18; rcv_idle_pct = 53; end
            1:       begin send_idle_pct = 53; rcv_idle_pct = 18; end
            default: begin send_idle_pct = 0;  rcv_idle_pct = 0;  end
         endcase
         case ($urandom_range(0, 3))
            0:       walk_rate = 64'($urandom_range(1, 1000));
            1:       walk_rate = 64'($urandom_range(1_000_000, 2_000_000_000));
            2:       walk_rate = rand64() >> $urandom_range(16, 40);
            default: walk_rate = 64'd1;
         endcase
         if (walk_rate == 0) walk_rate = 64'd1;
         for (int k = 0; k < BEATS_PER_PHASE; k++) begin
            send_beat(next_random_beat(), 1'b0, no_pin);
            if ($urandom_range(0, 99) == 0) drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run: %0d request beats (%0d directed), %0d results, %0d min_seconds writes",
               beats_sent, directed_beats, results_seen, csr_writes);
      $display("run: %0d recalibrations, %0d calibrated reads, idle mixes 18/53, 53/18, none",
               recal_count, cal_read_count);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
